>>> rtl/core/agsc_pkg.sv
// ----------------------------------------------------------------------------
// agsc_pkg: shared types and constants for the gear selector
// Holds the field widths, mode codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package agsc_pkg;

  localparam int NumGears = 8;
  localparam int GearW    = 3;

  // input modes
  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_NEUTRAL = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_FORWARD = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_RATIO_LOW  = 2'd0;
  localparam logic [1:0] REG_RATIO_HIGH = 2'd1;
  localparam logic [1:0] REG_GEAR_COUNT = 2'd2;

  // Q16.20 constants
  localparam logic signed [35:0] ONE_Q20   = 36'sd1048576;
  localparam logic signed [35:0] HALF_Q20  = 36'sd524288;
  localparam logic signed [35:0] THREE_Q20 = 36'sd3145728;
  localparam logic [31:0]        TICKS_ONE = 32'd1024;

  // divider request / response between the sequencer and the divider
  typedef struct packed {
    logic        start;
    logic [37:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/agsc_div.sv
// ----------------------------------------------------------------------------
// agsc_div: restoring divider for 2^30 / den
// One quotient bit per cycle, 31 quotient bits per division.
// ----------------------------------------------------------------------------
module agsc_div
  import agsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [37:0] rem_r, rem_nxt;
  logic [37:0] den_r;
  logic [30:0] quot_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [38:0] trial;

  // shift in the next dividend bit (only bit 30 of 2^30 is set)
  assign rem_nxt = {rem_r[36:0], (cnt_r == 5'd30)};
  assign trial   = {1'b0, rem_nxt} - {1'b0, den_r};

  // one bit per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == 5'd0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd30;
        rem_r  <= '0;
        den_r  <= req.den;
        quot_r <= '0;
      end else if (busy_r) begin
        if (!trial[38]) begin
          rem_r  <= trial[37:0];
          quot_r <= {quot_r[29:0], 1'b1};
        end else begin
          rem_r  <= rem_nxt;
          quot_r <= {quot_r[29:0], 1'b0};
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = {1'b0, quot_r};

endmodule

>>> rtl/core/auto_gear_shift_controller_core.sv
// ----------------------------------------------------------------------------
// auto_gear_shift_controller_core: automatic gear selector
// Usage:
//   in_tuser carries the mode and in_tdata the speed and now_time of a beat.
//   out_tdata returns one result per item: changed, engaged gear, target gear,
//   no_match. cfg_* writes the ratio tables and gear count; the user must do
//   so only while idle, as the block itself does not enforce it.
// Sequence:
//   a select item first checks the engaged ratio and gear 0, then one
//   table entry per cycle. An update takes upshift and then downshift
//   steps; each upshift waits on the shared 31-step divider, as does a
//   downshift below one half (others use the fixed one-second delay).
//   A new item is taken only once the result is loaded for output.
// Reset: ratios clear, gear count goes to 2, engaged/wanted gear and
//   deadline clear. No clearing pass.
// Stall: the result waits in the output register; the next item is taken
//   and worked on, and holds at its last step until the register is free.
// ----------------------------------------------------------------------------
module auto_gear_shift_controller_core
  import agsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic [47:0] in_tdata,   // speed[15:0], now_time[47:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // changed[0], engaged[3:1], target[6:4], no_match[7]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_UPCHK, S_DNCHK, S_WAIT, S_FIN, S_SEL, S_OUT
  } state_t;

  state_t       state_r;
  logic [63:0]  tab_lo_r, tab_hi_r;
  logic [3:0]   gcount_r;
  logic [2:0]   cur_r, want_r, sel_r;
  logic [31:0]  dl_r, now_r;
  logic [15:0]  speed_r;
  logic [1:0]   mode_r;
  logic signed [35:0] p_r;
  logic         dir_up_r;
  logic [3:0]   idx_r;
  logic         chg_r, miss_r;
  logic [7:0]   out_r;
  logic         out_v_r;
  div_req_t     dreq;
  div_rsp_t     drsp;

  // ratio lookup for the selector index
  function automatic logic signed [15:0] ratio_of(input logic [2:0] g,
                                                  input logic [63:0] lo,
                                                  input logic [63:0] hi);
    logic [63:0] w;
    begin
      w = g[2] ? hi : lo;
      ratio_of = w[{g[1:0], 4'd0} +: 16];
    end
  endfunction

  function automatic logic ratio_fits(input logic signed [15:0] r, input logic [1:0] k);
    begin
      case (k)
        MODE_NEUTRAL: ratio_fits = (r >= -16'sd4) && (r <= 16'sd4);
        MODE_REVERSE: ratio_fits = r[15];
        default:      ratio_fits = !r[15] && (r != 16'sd0);
      endcase
    end
  endfunction

  // signed later: a strictly after b
  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    begin
      d = a - b;
      later = (d != 32'd0) && !d[31];
    end
  endfunction

  logic [3:0] cnt_used;
  assign cnt_used = (gcount_r < 4'd2) ? 4'd2 :
                    (gcount_r > 4'(NumGears)) ? 4'(NumGears) : gcount_r;

  logic signed [15:0] r_sel, r_cur, r_idx;
  assign r_sel = ratio_of(sel_r, tab_lo_r, tab_hi_r);
  assign r_cur = ratio_of(cur_r, tab_lo_r, tab_hi_r);
  assign r_idx = ratio_of(idx_r[2:0], tab_lo_r, tab_hi_r);

  logic up_go, dn_go;
  logic signed [38:0] p5;
  assign p5    = 39'(p_r) + (39'(p_r) <<< 2);
  assign up_go = ({1'b0, sel_r} < cnt_used - 4'd1) && (p_r >= ONE_Q20);
  assign dn_go = (sel_r > 3'd1) && (p5 <= 39'(THREE_Q20));

  logic signed [37:0] den_up, den_dn;
  assign den_up = (38'(p_r) <<< 2) - 38'(THREE_Q20);
  assign den_dn = 38'(THREE_Q20) - (38'(p_r) <<< 2);

  logic [2:0] step_g;
  logic [31:0] ticks_dn_fix;
  assign step_g       = dir_up_r ? sel_r + 3'd1 : sel_r - 3'd1;
  assign ticks_dn_fix = TICKS_ONE;

  // apply one shift request
  logic [2:0]  want_req;
  logic [31:0] dl_req;
  always_comb begin
    logic [31:0] ch;
    logic keep;
    ch   = now_r + (drsp.done ? drsp.quot : ticks_dn_fix);
    keep = dir_up_r ? (want_r >= step_g) : (want_r <= step_g);
    want_req = want_r;
    dl_req   = dl_r;
    if (keep) begin
      if (later(dl_r, ch)) dl_req = ch;
    end else begin
      want_req = step_g;
      dl_req   = ch;
    end
  end

  // divider request
  always_comb begin
    dreq.den   = dir_up_r ? den_up : den_dn;
    dreq.start = 1'b0;
    if (state_r == S_UPCHK && up_go) dreq.start = 1'b1;
    if (state_r == S_DNCHK && dn_go && (p_r < HALF_Q20)) dreq.start = 1'b1;
  end

  agsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tab_lo_r <= '0;
      tab_hi_r <= '0;
      gcount_r <= 4'd2;
      cur_r    <= '0;
      want_r   <= '0;
      dl_r     <= '0;
      out_v_r  <= 1'b0;
      dir_up_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_RATIO_LOW:  tab_lo_r <= cfg_data;
          REG_RATIO_HIGH: tab_hi_r <= cfg_data;
          REG_GEAR_COUNT: gcount_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      // result register: load when free, clear once taken
      if (state_r == S_OUT && (!out_v_r || out_tready)) out_v_r <= 1'b1;
      else if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          mode_r  <= in_tuser;
          speed_r <= in_tdata[15:0];
          now_r   <= in_tdata[47:16];
          chg_r   <= 1'b0;
          miss_r  <= 1'b0;
          idx_r   <= '0;
          sel_r   <= (cur_r == 3'd0) ? 3'd1 : cur_r;
          dir_up_r <= 1'b1;
          state_r <= (in_tuser == MODE_UPDATE) ? S_MUL : S_SEL;
        end
        S_MUL: begin
          p_r     <= 36'($signed({1'b0, speed_r}) * r_sel);
          state_r <= dir_up_r ? S_UPCHK : S_DNCHK;
        end
        S_UPCHK: begin
          if (up_go) state_r <= S_WAIT;
          else begin
            dir_up_r <= 1'b0;
            state_r  <= S_DNCHK;
          end
        end
        S_DNCHK: begin
          if (!dn_go) state_r <= S_FIN;
          else if (p_r < HALF_Q20) state_r <= S_WAIT;
          else begin
            want_r  <= want_req;
            dl_r    <= dl_req;
            sel_r   <= step_g;
            state_r <= S_MUL;
          end
        end
        S_WAIT: if (drsp.done) begin
          want_r  <= want_req;
          dl_r    <= dl_req;
          sel_r   <= step_g;
          state_r <= S_MUL;
        end
        S_FIN: begin
          if (want_r != cur_r && !later(dl_r, now_r)) begin
            cur_r <= want_r;
            chg_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        // first pass checks the engaged ratio and entry zero, then scans on
        S_SEL: begin
          if (idx_r == 4'd0 && ratio_fits(r_cur, mode_r)) state_r <= S_OUT;
          else if (idx_r >= cnt_used) begin
            miss_r  <= 1'b1;
            state_r <= S_OUT;
          end else if (ratio_fits(r_idx, mode_r)) begin
            cur_r   <= idx_r[2:0];
            chg_r   <= 1'b1;
            state_r <= S_OUT;
          end else idx_r <= idx_r + 4'd1;
        end
        S_OUT: if (!out_v_r || out_tready) begin
          out_r   <= {miss_r, want_r, cur_r, chg_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  a_miss_no_chg: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r[0] && out_r[7])) else $error("changed with no match");

endmodule

>>> sim/tb_gear_checker.sv
// ----------------------------------------------------------------------------
// tb_gear_checker: result predictor and scoreboard for the gear selector
// Watches the config, input and result channels, models the gear selection
// and shift deadline logic, and compares each result beat with its prediction.
// ----------------------------------------------------------------------------
module tb_gear_checker
  import agsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic       no_match;
    logic [2:0] target;
    logic [2:0] engaged;
    logic       changed;
  } gear_result_t;

  // model state
  logic [63:0] tbl_lo, tbl_hi;
  logic [3:0]  cnt_reg;
  logic [2:0]  eng_gear, want_gear;
  logic [31:0] deadline;
  gear_result_t result_q[$];

  assign pending_results = result_q.size();

  function automatic logic signed [15:0] ratio_at(input logic [2:0] g);
    logic [63:0] w;
    w = g[2] ? tbl_hi : tbl_lo;
    return w[16*g[1:0] +: 16];
  endfunction

  function automatic int gears_in_use();
    if (cnt_reg < 2) return 2;
    if (cnt_reg > NumGears) return NumGears;
    return cnt_reg;
  endfunction

  function automatic bit is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  function automatic void ask_shift(input int g, input logic [31:0] ticks,
                                    input logic [31:0] now, input bit up);
    logic [31:0] due;
    bit hold;
    due = now + ticks;
    hold = up ? (want_gear >= g) : (want_gear <= g);
    if (hold) begin
      if (is_later(deadline, due)) deadline = due;
    end else begin
      want_gear = g[2:0];
      deadline = due;
    end
  endfunction

  function automatic bit kind_fits(input logic signed [15:0] r, input mode_t k);
    case (k)
      MODE_NEUTRAL: return r >= -4 && r <= 4;
      MODE_REVERSE: return r < 0;
      default:      return r > 0;
    endcase
  endfunction

  function automatic gear_result_t predict_gear(input logic [1:0] user,
                                                input logic [47:0] beat);
    mode_t       md;
    logic [15:0] spd;
    logic [31:0] now;
    longint      p, one;
    int          c, sel;
    logic [31:0] ticks;
    gear_result_t r;
    md  = mode_t'(user);
    spd = beat[15:0];
    now = beat[47:16];
    one = 64'sd1 << 20;
    c   = gears_in_use();
    r   = '0;
    if (md == MODE_UPDATE) begin
      sel = (eng_gear < 1) ? 1 : eng_gear;
      p = longint'(spd) * longint'(ratio_at(sel[2:0]));
      while (sel < c - 1 && p >= one) begin
        ticks = 32'((64'sd1 << 30) / (4 * p - 3 * one));
        sel++;
        ask_shift(sel, ticks, now, 1'b1);
        p = longint'(spd) * longint'(ratio_at(sel[2:0]));
      end
      while (sel > 1 && 5 * p <= 3 * one) begin
        ticks = TICKS_ONE;
        if (p < one / 2) ticks = 32'((64'sd1 << 30) / (3 * one - 4 * p));
        sel--;
        ask_shift(sel, ticks, now, 1'b0);
        p = longint'(spd) * longint'(ratio_at(sel[2:0]));
      end
      if (want_gear != eng_gear && !is_later(deadline, now)) begin
        eng_gear = want_gear;
        r.changed = 1'b1;
      end
    end else if (!kind_fits(ratio_at(eng_gear), md)) begin
      r.no_match = 1'b1;
      for (int g = 0; g < c; g++) begin
        if (kind_fits(ratio_at(g[2:0]), md)) begin
          eng_gear = g[2:0];
          r.changed = 1'b1;
          r.no_match = 1'b0;
          break;
        end
      end
    end
    r.engaged = eng_gear;
    r.target  = want_gear;
    return r;
  endfunction

  // watch all channels at the rising edge
  always @(posedge clk) begin
    gear_result_t want, got;
    if (!rst_n) begin
      tbl_lo = '0; tbl_hi = '0; cnt_reg = 4'd2;
      eng_gear = '0; want_gear = '0; deadline = '0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATIO_LOW:  tbl_lo = cfg_data;
          REG_RATIO_HIGH: tbl_hi = cfg_data;
          REG_GEAR_COUNT: cnt_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        result_q.push_back(predict_gear(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display({"mismatch: exp chg=%0d eng=%0d tgt=%0d nm=%0d,",
                        " got chg=%0d eng=%0d tgt=%0d nm=%0d"},
                       want.changed, want.engaged, want.target, want.no_match,
                       got.changed, got.engaged, got.target, got.no_match);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the gear selector
// Writes ratio tables and gear counts between phases, drives directed and
// random items with varying sender and receiver idling, and reports the result.
// ----------------------------------------------------------------------------
module tb_top;
  import agsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready;
  logic [1:0]  in_tuser = '0;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid, out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count, pending_results;
  int          sender_idle = 0, receiver_stall = 0;
  int          hold_off = 0;
  logic        hold_req = 1'b0, hold_seen = 1'b0;
  longint      cycle_count = 0;
  logic [31:0] clock_ticks = '0;

  always #5 clk = ~clk;

  auto_gear_shift_controller_core u_dut (.*);

  tb_gear_checker u_chk (.*);

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_off   <= 3000;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else
      out_tready <= ($urandom_range(0, 99) >= receiver_stall);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input mode_t md, input logic [15:0] spd,
                           input logic [31:0] now);
    while ($urandom_range(0, 99) < sender_idle) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = md;
    in_tdata  = {now, spd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [15:0] random_ratio();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 8)) - 4);
      1: return 16'(-$signed($urandom_range(1, 32768)));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(256, 12000));
    endcase
  endfunction

  task automatic load_table(input int count);
    logic [63:0] lo, hi;
    for (int i = 0; i < 4; i++) begin
      lo[16*i +: 16] = random_ratio();
      hi[16*i +: 16] = random_ratio();
    end
    write_reg(REG_RATIO_LOW, lo);
    write_reg(REG_RATIO_HIGH, hi);
    write_reg(REG_GEAR_COUNT, 64'(count[3:0]));
  endtask

  // time mostly advances, sometimes jumps, so deadlines pass
  task automatic random_item();
    int k;
    logic [15:0] spd;
    k = $urandom_range(0, 9);
    clock_ticks = clock_ticks + (($urandom_range(0, 3) == 0) ?
                  $urandom : $urandom_range(0, 1500));
    case ($urandom_range(0, 3))
      0: spd = 16'($urandom);
      1: spd = 16'($urandom_range(0, 255));
      default: spd = 16'($urandom_range(32, 1024));
    endcase
    if (k < 7) send_item(MODE_UPDATE, spd, clock_ticks);
    else send_item(mode_t'($urandom_range(1, 3)), spd, clock_ticks);
  endtask

  initial begin
    int idle_set[4][2];
    idle_set = '{'{0, 0}, '{77, 0}, '{0, 77}, '{26, 26}};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset table (all neutral), then a ladder of ratios
    send_item(MODE_UPDATE, 16'hFFFF, 32'h0);
    send_item(MODE_REVERSE, 16'h0, 32'h0);
    send_item(MODE_FORWARD, 16'h0, 32'h0);
    send_item(MODE_NEUTRAL, 16'h0, 32'h0);
    wait_drained();
    write_reg(REG_RATIO_LOW, 64'h1000_2000_8000_0004);
    write_reg(REG_RATIO_HIGH, 64'hFFFC_7FFF_0400_0800);
    write_reg(REG_GEAR_COUNT, 64'd15);
    send_item(MODE_REVERSE, 16'h0, 32'd10);
    send_item(MODE_FORWARD, 16'h0, 32'd20);
    send_item(MODE_FORWARD, 16'h0, 32'd30);
    send_item(MODE_UPDATE, 16'h0100, 32'd40);
    send_item(MODE_UPDATE, 16'h0100, 32'd5000);
    send_item(MODE_UPDATE, 16'hFFFF, 32'hFFFF_FF00);
    send_item(MODE_UPDATE, 16'hFFFF, 32'h0000_1000);
    send_item(MODE_UPDATE, 16'h0000, 32'h0000_2000);
    send_item(MODE_UPDATE, 16'h0000, 32'h8000_2000);
    send_item(MODE_NEUTRAL, 16'h0, 32'h8000_3000);
    send_item(MODE_UPDATE, 16'h0080, 32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_GEAR_COUNT, 64'd0);
    send_item(MODE_UPDATE, 16'h0200, 32'd0);
    send_item(MODE_NEUTRAL, 16'h0, 32'd1);
    send_item(MODE_REVERSE, 16'h0, 32'd2);
    wait_drained();

    // random phases with changing tables and counts
    for (int ph = 0; ph < 16; ph++) begin
      sender_idle = idle_set[ph % 4][0];
      receiver_stall = idle_set[ph % 4][1];
      load_table((ph == 0) ? 2 : (ph == 1) ? 8 : $urandom_range(0, 15));
      if (ph == 5) hold_req = ~hold_req;
      for (int i = 0; i < 70; i++) random_item();
      wait_drained();
    end

    sender_idle = 0; receiver_stall = 0;
    wait_drained();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/agsc_pkg.sv
rtl/core/agsc_div.sv
rtl/core/auto_gear_shift_controller_core.sv
sim/tb_gear_checker.sv
sim/tb_top.sv
